/* sv/dpm_pkg.sv */
// ----------------------------------------------------------------------------
// dpm_pkg
// Shared types and constants of the detector pixel mapper.
// ----------------------------------------------------------------------------
package dpm_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PosW     = 32;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned ProdW    = PosW + CoefW;
  localparam int unsigned SumW     = ProdW + 1;
  localparam int unsigned MatFracW = 24;
  localparam int unsigned ShiftW   = SumW - MatFracW;
  localparam int unsigned CoordW   = ShiftW + 1;
  localparam int unsigned FracW    = 16;
  localparam int unsigned IdxW     = 16;
  localparam int unsigned BorderW  = 16;
  localparam int unsigned CmpW     = CoordW - FracW - 1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MATRIX_XX = 3'd0,
    REG_MATRIX_XY = 3'd1,
    REG_MATRIX_YX = 3'd2,
    REG_MATRIX_YY = 3'd3,
    REG_OFFSET_X  = 3'd4,
    REG_OFFSET_Y  = 3'd5,
    REG_BORDER_X  = 3'd6,
    REG_BORDER_Y  = 3'd7
  } dpm_reg_e;

  typedef struct packed {
    logic signed [CoefW-1:0]   matrix_xx;
    logic signed [CoefW-1:0]   matrix_xy;
    logic signed [CoefW-1:0]   matrix_yx;
    logic signed [CoefW-1:0]   matrix_yy;
    logic signed [PosW-1:0]    offset_x;
    logic signed [PosW-1:0]    offset_y;
    logic        [BorderW-1:0] border_x;
    logic        [BorderW-1:0] border_y;
  } dpm_cfg_t;

endpackage

/* sv/dpm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dpm_cfg_regs
// Configuration register file: matrix, offsets and dead borders.
// ----------------------------------------------------------------------------
module dpm_cfg_regs import dpm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgAddrW-1:0] wr_addr_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output dpm_cfg_t            cfg_o
);

  dpm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (dpm_reg_e'(wr_addr_i))
        REG_MATRIX_XX: cfg_d.matrix_xx = wr_data_i;
        REG_MATRIX_XY: cfg_d.matrix_xy = wr_data_i;
        REG_MATRIX_YX: cfg_d.matrix_yx = wr_data_i;
        REG_MATRIX_YY: cfg_d.matrix_yy = wr_data_i;
        REG_OFFSET_X:  cfg_d.offset_x  = wr_data_i;
        REG_OFFSET_Y:  cfg_d.offset_y  = wr_data_i;
        REG_BORDER_X:  cfg_d.border_x  = wr_data_i[BorderW-1:0];
        REG_BORDER_Y:  cfg_d.border_y  = wr_data_i[BorderW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/dpm_coord.sv */
// ----------------------------------------------------------------------------
// dpm_coord
// One axis of the affine transform: two registered products, then the exact
// sum floored by 2^24 plus the offset, registered as a signed Q.16 coordinate.
// ----------------------------------------------------------------------------
module dpm_coord import dpm_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [CoefW-1:0]  coef_a_i,
  input  logic signed [CoefW-1:0]  coef_b_i,
  input  logic signed [PosW-1:0]   pos_a_i,
  input  logic signed [PosW-1:0]   pos_b_i,
  input  logic signed [PosW-1:0]   offset_i,
  output logic signed [CoordW-1:0] coord_o
);

  logic signed [ProdW-1:0]  prod_a_q, prod_a_d;
  logic signed [ProdW-1:0]  prod_b_q, prod_b_d;
  logic signed [SumW-1:0]   sum;
  logic signed [ShiftW-1:0] sum_floor;
  logic signed [CoordW-1:0] coord_q, coord_d;

  assign prod_a_d = coef_a_i * pos_a_i;
  assign prod_b_d = coef_b_i * pos_b_i;

  always_comb begin
    sum       = SumW'(prod_a_q) + SumW'(prod_b_q);
    sum_floor = sum[SumW-1:MatFracW];
    coord_d   = CoordW'(sum_floor) + CoordW'(offset_i);
  end

  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    coord_q  <= coord_d;
  end

  assign coord_o = coord_q;

endmodule

/* sv/dpm_axis.sv */
// ----------------------------------------------------------------------------
// dpm_axis
// Split one coordinate into pixel index and fraction; check grid range and
// dead border.
// ----------------------------------------------------------------------------
module dpm_axis import dpm_pkg::*; #(
  parameter int unsigned LIMIT = 64
) (
  input  logic signed [CoordW-1:0] coord_i,
  input  logic [BorderW-1:0]       border_i,
  output logic                     ok_o,
  output logic [IdxW-1:0]          idx_o,
  output logic [FracW-1:0]         frac_o
);

  localparam logic [CmpW-1:0] LimitC = CmpW'(LIMIT);

  logic [CmpW-1:0]  idx_mag;
  logic [FracW:0]   frac_rem;
  logic             in_grid;
  logic             in_border;

  always_comb begin
    idx_mag   = coord_i[CoordW-2:FracW];
    frac_rem  = (FracW+1)'(1 << FracW) - {1'b0, coord_i[FracW-1:0]};
    in_grid   = !coord_i[CoordW-1] && (idx_mag < LimitC);
    in_border = (coord_i[FracW-1:0] < border_i) || (frac_rem < {1'b0, border_i});
    ok_o      = in_grid && !in_border;
    idx_o     = idx_mag[IdxW-1:0];
    frac_o    = coord_i[FracW-1:0];
  end

endmodule

/* sv/detector_pixel_mapper_core.sv */
// ----------------------------------------------------------------------------
// detector_pixel_mapper_core
// Maps an impact position to a detector pixel index and in-pixel fraction.
// ----------------------------------------------------------------------------
// Pipeline: each start beat passes the input, product, coordinate and result
//   registers, in that order, before its result strobe.
// Throughput: one item per cycle once busy drops; every stage is registered.
// Receiver cannot stall; each result is shown for exactly one cycle.
// Reset: all configuration registers clear to zero; busy is high during
//   reset and until the first rising clock edge after it.
module detector_pixel_mapper_core import dpm_pkg::*; #(
  parameter int unsigned GRID_WIDTH  = 64,
  parameter int unsigned GRID_HEIGHT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                result_valid_o,
  output logic                hit_valid_o,
  output logic [IdxW-1:0]     pixel_x_o,
  output logic [IdxW-1:0]     pixel_y_o,
  output logic [FracW-1:0]    frac_x_o,
  output logic [FracW-1:0]    frac_y_o
);

  dpm_cfg_t cfg;

  logic busy_q;
  logic accept;
  logic [2:0] stage_vld_q, stage_vld_d;

  logic signed [PosW-1:0]   pos_x_q, pos_y_q;
  logic signed [CoordW-1:0] coord_x, coord_y;
  logic                     ok_x, ok_y, hit;
  logic [IdxW-1:0]          idx_x, idx_y;
  logic [FracW-1:0]         fr_x, fr_y;

  logic                     res_vld_q;
  logic                     hit_q, hit_d;
  logic [IdxW-1:0]          pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [FracW-1:0]         frc_x_q, frc_x_d, frc_y_q, frc_y_d;

  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;
  assign accept      = start && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  dpm_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
    end
  end

  dpm_coord u_coord_x (
    .clk_i    (clk_i),
    .coef_a_i (cfg.matrix_xx),
    .coef_b_i (cfg.matrix_xy),
    .pos_a_i  (pos_x_q),
    .pos_b_i  (pos_y_q),
    .offset_i (cfg.offset_x),
    .coord_o  (coord_x)
  );

  dpm_coord u_coord_y (
    .clk_i    (clk_i),
    .coef_a_i (cfg.matrix_yx),
    .coef_b_i (cfg.matrix_yy),
    .pos_a_i  (pos_x_q),
    .pos_b_i  (pos_y_q),
    .offset_i (cfg.offset_y),
    .coord_o  (coord_y)
  );

  dpm_axis #(.LIMIT(GRID_WIDTH)) u_axis_x (
    .coord_i  (coord_x),
    .border_i (cfg.border_x),
    .ok_o     (ok_x),
    .idx_o    (idx_x),
    .frac_o   (fr_x)
  );

  dpm_axis #(.LIMIT(GRID_HEIGHT)) u_axis_y (
    .coord_i  (coord_y),
    .border_i (cfg.border_y),
    .ok_o     (ok_y),
    .idx_o    (idx_y),
    .frac_o   (fr_y)
  );

  assign hit         = ok_x && ok_y;
  assign stage_vld_d = {stage_vld_q[1:0], accept};

  always_comb begin
    hit_d   = hit;
    pix_x_d = hit ? idx_x : '0;
    pix_y_d = hit ? idx_y : '0;
    frc_x_d = hit ? fr_x  : '0;
    frc_y_d = hit ? fr_y  : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
      res_vld_q   <= stage_vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_vld_q[2]) begin
      hit_q   <= hit_d;
      pix_x_q <= pix_x_d;
      pix_y_q <= pix_y_d;
      frc_x_q <= frc_x_d;
      frc_y_q <= frc_y_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign hit_valid_o    = hit_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign frac_x_o       = frc_x_q;
  assign frac_y_o       = frc_y_q;

endmodule

/* sv/dpm_checker.sv */
// ----------------------------------------------------------------------------
// dpm_checker
// Port-level checks of the pixel mapper: result timing and result contents.
// ----------------------------------------------------------------------------
module dpm_checker import dpm_pkg::*; #(
  parameter int unsigned GRID_WIDTH  = 64,
  parameter int unsigned GRID_HEIGHT = 64
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input logic             hit_valid_o,
  input logic [IdxW-1:0]  pixel_x_o,
  input logic [IdxW-1:0]  pixel_y_o,
  input logic [FracW-1:0] frac_x_o,
  input logic [FracW-1:0] frac_y_o
);

  logic accept;
  assign accept = start && !busy;

  a_result_follows_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 result_valid_o)
    else $error("missing result four cycles after start beat");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 4))
    else $error("result without matching start beat");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hit_valid_o) |->
      (pixel_x_o == '0 && pixel_y_o == '0 && frac_x_o == '0 && frac_y_o == '0))
    else $error("invalid hit carries nonzero fields");

  a_hit_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_valid_o) |->
      (32'(pixel_x_o) < GRID_WIDTH && 32'(pixel_y_o) < GRID_HEIGHT))
    else $error("hit index outside grid");

endmodule

bind detector_pixel_mapper_core dpm_checker #(
  .GRID_WIDTH  (GRID_WIDTH),
  .GRID_HEIGHT (GRID_HEIGHT)
) u_dpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .hit_valid_o    (hit_valid_o),
  .pixel_x_o      (pixel_x_o),
  .pixel_y_o      (pixel_y_o),
  .frac_x_o       (frac_x_o),
  .frac_y_o       (frac_y_o)
);
